[hdl/qat_pkg.sv]
`default_nettype none
package qat_pkg;

  // byte codes the tokenizer reacts to
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NUL       = 8'h00;

  // quote mode codes
  typedef logic [1:0] qmode_t;
  localparam qmode_t QM_NONE = 2'd0;
  localparam qmode_t QM_DQ   = 2'd1;
  localparam qmode_t QM_SQ   = 2'd2;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one classified byte: which results it causes, in emission order
  typedef struct packed {
    logic [7:0] ch;      // byte to append when emit_ch
    logic       emit_bs; // literal backslash first
    logic       emit_ch; // the byte itself
    logic       emit_td; // token end
    logic       emit_mk; // bare end-of-input mark
    logic       fin;     // last byte of the string
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       token_done;
    logic       input_done;
    logic       run_last;
  } res_t;

endpackage
`default_nettype wire

[hdl/qat_if.sv]
`default_nettype none
interface qat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       is_final;

  modport source (output valid, output in_char, output is_final, input ready);
  modport sink   (input valid, input in_char, input is_final, output ready);
endinterface

interface qat_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       token_done;
  logic       input_done;
  logic       run_last;

  modport source (output valid, output out_char, output char_valid, output token_done,
                  output input_done, output run_last, input ready);
  modport sink   (input valid, input out_char, input char_valid, input token_done,
                  input input_done, input run_last, output ready);
endinterface
`default_nettype wire

[hdl/qat_front.sv]
`default_nettype none
module qat_front import qat_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  qat_in_if.sink    byte_in,
  output cmd_t      push_cmd,
  output logic      push,
  input  wire logic q_full
);

  qmode_t quote_mode, quote_mode_next;
  logic   token_open, token_open_next;
  logic   backslash_pending, backslash_pending_next;

  logic       accept;
  logic [7:0] c;
  logic       fin;
  logic [7:0] qbyte;
  logic       pend, esc;
  logic       bs_e, ch_e, td_e;

  assign byte_in.ready = !q_full;
  assign accept = byte_in.valid && byte_in.ready;
  assign c   = byte_in.in_char;
  assign fin = byte_in.is_final;

  always_comb begin
    qbyte = (quote_mode == QM_SQ) ? CH_SQUOTE : CH_DQUOTE;
    pend  = backslash_pending && (quote_mode != QM_NONE);
    esc   = pend && ((c == qbyte) || (c == CH_BACKSLASH));
    bs_e  = pend && !esc;
    quote_mode_next        = quote_mode;
    token_open_next        = token_open;
    backslash_pending_next = 1'b0;
    ch_e = 1'b0;
    td_e = 1'b0;
    if (esc) begin
      ch_e = 1'b1;
    end else if (quote_mode != QM_NONE) begin
      if (c == qbyte) begin
        quote_mode_next = QM_NONE;
      end else if ((c == CH_BACKSLASH) && !fin) begin
        backslash_pending_next = 1'b1;
      end else begin
        ch_e = 1'b1;
      end
    end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
      quote_mode_next = (c == CH_SQUOTE) ? QM_SQ : QM_DQ;
      token_open_next = 1'b1;
    end else if ((c == CH_SPACE) || (c == CH_TAB)) begin
      if (token_open) begin
        td_e            = 1'b1;
        token_open_next = 1'b0;
      end
    end else begin
      ch_e            = 1'b1;
      token_open_next = 1'b1;
    end
    // flush an open token on the last byte
    if (fin && token_open_next) begin
      td_e = 1'b1;
    end
    push_cmd.ch      = ch_e ? c : CH_NUL;
    push_cmd.emit_bs = bs_e;
    push_cmd.emit_ch = ch_e;
    push_cmd.emit_td = td_e;
    push_cmd.emit_mk = fin && !td_e;
    push_cmd.fin     = fin;
    push = accept && (bs_e || ch_e || td_e || fin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode        <= QM_NONE;
      token_open        <= 1'b0;
      backslash_pending <= 1'b0;
    end else if (accept) begin
      if (fin) begin
        quote_mode        <= QM_NONE;
        token_open        <= 1'b0;
        backslash_pending <= 1'b0;
      end else begin
        quote_mode        <= quote_mode_next;
        token_open        <= token_open_next;
        backslash_pending <= backslash_pending_next;
      end
    end
  end

  // an escape can only be pending inside a quoted span
  assert property (@(posedge clk) disable iff (rst)
    backslash_pending |-> (quote_mode != QM_NONE))
    else $error("backslash pending outside quotes");

endmodule
`default_nettype wire

[hdl/qat_queue.sv]
`default_nettype none
module qat_queue import qat_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t push_cmd,
  input  wire logic push,
  output logic      full,
  output cmd_t      head,
  output logic      empty,
  input  wire logic pop
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (push && full) |=> (count == QCNT_W'(QDEPTH)))
    else $error("push into full queue changed fill level");

endmodule
`default_nettype wire

[hdl/qat_back.sv]
`default_nettype none
module qat_back import qat_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t head,
  input  wire logic q_empty,
  output logic      pop,
  qat_out_if.source result_out
);

  // pending results of the current command: {mark, token end, byte, backslash}
  logic [3:0] rem;
  logic [3:0] sel;
  logic [3:0] rem_after;
  logic [7:0] cur_ch;
  logic       cur_fin;
  logic       cur_valid;
  res_t       res, res_next;
  logic       out_valid;
  logic       out_free, advance, last, load;

  always_comb begin
    priority if (rem[0]) sel = 4'b0001;
    else if (rem[1])     sel = 4'b0010;
    else if (rem[2])     sel = 4'b0100;
    else                 sel = 4'b1000;
    rem_after = rem & ~sel;
    last      = (rem_after == 4'b0000);
    out_free  = !out_valid || result_out.ready;
    advance   = cur_valid && out_free;
    load      = !q_empty && (!cur_valid || (advance && last));
    pop       = load;

    res_next.out_char   = sel[0] ? CH_BACKSLASH : (sel[1] ? cur_ch : CH_NUL);
    res_next.char_valid = sel[0] || sel[1];
    res_next.token_done = sel[2];
    res_next.input_done = (sel[2] && cur_fin) || sel[3];
    res_next.run_last   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        cur_valid <= 1'b1;
      end else if (advance && last) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
    if (load) begin
      rem     <= {head.emit_mk, head.emit_td, head.emit_ch, head.emit_bs};
      cur_ch  <= head.ch;
      cur_fin <= head.fin;
    end else if (advance) begin
      rem <= rem_after;
    end
  end

  assign result_out.valid      = out_valid;
  assign result_out.out_char   = res.out_char;
  assign result_out.char_valid = res.char_valid;
  assign result_out.token_done = res.token_done;
  assign result_out.input_done = res.input_done;
  assign result_out.run_last   = res.run_last;

  // every result is a byte, a token end or a bare mark, never two
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({res.char_valid, res.token_done,
                           res.input_done && !res.token_done}))
    else $error("result is not exactly one kind");

  // end of input is always the last result of its byte
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.input_done) |-> res.run_last)
    else $error("input_done without run_last");

  // a live command always has something left to emit
  assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (rem != 4'b0000))
    else $error("empty command held by sequencer");

endmodule
`default_nettype wire

[hdl/quoted_argument_tokenizer_unit.sv]
`default_nettype none
// channel     dir  payload                                          transfer
// byte_in     in   in_char[7:0], is_final                           valid & ready
// result_out  out  out_char[7:0], char_valid, token_done,           valid & ready
//                  input_done, run_last
//
// one byte per cycle is taken while the command queue has room
// a byte yields 0 to 3 results; the back end sends one result per cycle
// while result_out is not stalled
// first result of a byte passes through the queue, the sequencer and the output register
// rst is synchronous: clears quote state, queue pointers and output valid
// output stall fills the queue, then byte_in.ready drops; no transfer is lost
module quoted_argument_tokenizer_unit import qat_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  qat_in_if.sink    byte_in,
  qat_out_if.source result_out
);

  // classified byte into the queue
  cmd_t push_cmd;
  logic push;
  logic q_full;

  // queue head into the result sequencer
  cmd_t head;
  logic q_empty;
  logic pop;

  // front: quote/escape tracking, decides which results a byte causes
  qat_front u_front (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_in),
    .push_cmd (push_cmd),
    .push     (push),
    .q_full   (q_full)
  );

  // short queue decoupling classification from result emission
  qat_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_cmd (push_cmd),
    .push     (push),
    .full     (q_full),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop)
  );

  // back: unrolls each command into results behind an output register
  qat_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .result_out (result_out)
  );

endmodule
`default_nettype wire

[test/quoted_argument_tokenizer_unit_test.sv]
`timescale 1ns / 100ps
`default_nettype none
module quoted_argument_tokenizer_unit_test;
  import qat_pkg::*;

  localparam int RANDOM_ITEMS   = 84;
  localparam int STALL_PERCENT  = 29;
  localparam int WATCHDOG_LIMIT = 2000;
  // extra wait after every owed result is out, to catch stray results
  localparam int DRAIN_CYCLES   = 8;
  localparam int REPORT_LIMIT   = 10;

  logic clk = 1'b0;
  logic rst;

  qat_in_if  byte_in_if ();
  qat_out_if result_if ();

  quoted_argument_tokenizer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in_if),
    .result_out (result_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tokenizer state as the testbench sees it
  qmode_t quote_state;
  logic   token_active;
  logic   escape_pending;

  // results owed by the block, oldest first
  res_t expected_results[$];
  // results of the byte being tokenized
  res_t step_results[$];

  int   fail_count;
  int   items_sent;
  int   quiet_cycles;
  // when set, neither side inserts gaps
  logic steady;

  function automatic void emit_result(logic [7:0] ch, logic cv, logic td, logic id);
    res_t r;
    r.out_char   = ch;
    r.char_valid = cv;
    r.token_done = td;
    r.input_done = id;
    r.run_last   = 1'b0;
    step_results.insert(step_results.size(), r);
  endfunction

  function automatic logic [7:0] closing_quote();
    return (quote_state == QM_SQ) ? CH_SQUOTE : CH_DQUOTE;
  endfunction

  // one byte with no escape in front of it
  function automatic void tokenize_plain(logic [7:0] c, logic fin);
    if (quote_state != QM_NONE) begin
      if (c == closing_quote()) begin
        quote_state = QM_NONE;
      end else if (c == CH_BACKSLASH && !fin) begin
        escape_pending = 1'b1;
      end else begin
        emit_result(c, 1'b1, 1'b0, 1'b0);
      end
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      // an opening quote opens a token even if the span stays empty
      quote_state  = (c == CH_SQUOTE) ? QM_SQ : QM_DQ;
      token_active = 1'b1;
    end else if (c == CH_SPACE || c == CH_TAB) begin
      if (token_active) begin
        emit_result(CH_NUL, 1'b0, 1'b1, 1'b0);
        token_active = 1'b0;
      end
    end else begin
      emit_result(c, 1'b1, 1'b0, 1'b0);
      token_active = 1'b1;
    end
  endfunction

  // works out the results of one accepted byte and queues them
  function automatic void tokenize_byte(logic [7:0] c, logic fin);
    step_results.delete();
    if (escape_pending && quote_state != QM_NONE) begin
      escape_pending = 1'b0;
      if (c == closing_quote() || c == CH_BACKSLASH) begin
        emit_result(c, 1'b1, 1'b0, 1'b0);
      end else begin
        // backslash not part of an escape: kept, then the byte goes on as usual
        emit_result(CH_BACKSLASH, 1'b1, 1'b0, 1'b0);
        tokenize_plain(c, fin);
      end
    end else begin
      escape_pending = 1'b0;
      tokenize_plain(c, fin);
    end

    if (fin) begin
      // flush an open token, even inside an unclosed quote
      if (token_active) begin
        emit_result(CH_NUL, 1'b0, 1'b1, 1'b0);
      end
      // end of input rides on a token end, else it needs a bare mark
      if (step_results.size() > 0 && step_results[step_results.size() - 1].token_done) begin
        step_results[step_results.size() - 1].input_done = 1'b1;
      end else begin
        emit_result(CH_NUL, 1'b0, 1'b0, 1'b1);
      end
      quote_state    = QM_NONE;
      token_active   = 1'b0;
      escape_pending = 1'b0;
    end

    if (step_results.size() > 0) begin
      step_results[step_results.size() - 1].run_last = 1'b1;
    end
    foreach (step_results[i]) begin
      expected_results.insert(expected_results.size(), step_results[i]);
    end
  endfunction

  function automatic void note_failure(string msg);
    if (fail_count < REPORT_LIMIT) begin
      $display("%0t: %s", $realtime, msg);
    end
    fail_count++;
  endfunction

  // called at a falling edge, returns at a falling edge after the transfer
  task automatic send_byte(input logic [7:0] c, input logic fin);
    while (!steady && $urandom_range(99) < STALL_PERCENT) begin
      byte_in_if.valid <= 1'b0;
      @(negedge clk);
    end
    byte_in_if.valid    <= 1'b1;
    byte_in_if.in_char  <= c;
    byte_in_if.is_final <= fin;
    do @(posedge clk); while (!byte_in_if.ready);
    tokenize_byte(c, fin);
    items_sent++;
    @(negedge clk);
  endtask

  // last byte of the text carries the final flag
  task automatic send_string(input logic [7:0] text[$]);
    foreach (text[i]) begin
      send_byte(text[i], i == text.size() - 1);
    end
  endtask

  // plain bytes, extremes of the byte range, tab and space, empty quoted token
  task automatic test_plain_words();
    send_string('{"x", 8'hFF, CH_TAB, CH_NUL, CH_SPACE, CH_SQUOTE, CH_SQUOTE});
  endtask

  // escapes inside double quotes, stray backslash before a space, unclosed quote
  task automatic test_double_quotes();
    send_string('{CH_DQUOTE, CH_BACKSLASH, CH_DQUOTE, CH_BACKSLASH, CH_BACKSLASH,
                  CH_BACKSLASH, "q", CH_BACKSLASH, CH_SPACE});
  endtask

  // escaped single quote, other quote after a backslash, backslash as last byte
  task automatic test_single_quotes();
    send_string('{CH_SQUOTE, CH_BACKSLASH, CH_SQUOTE, CH_BACKSLASH, CH_DQUOTE,
                  CH_BACKSLASH});
  endtask

  // final byte with no token (bare end mark) and final token end on a tab
  task automatic test_string_ends();
    send_string('{CH_SPACE});
    send_string('{CH_DQUOTE, CH_DQUOTE, CH_TAB});
  endtask

  // byte mix leaning on separators, quotes and backslashes
  function automatic logic [7:0] random_text_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) return CH_SPACE;
    if (pick < 18) return CH_TAB;
    if (pick < 25) return CH_DQUOTE;
    if (pick < 32) return CH_SQUOTE;
    if (pick < 45) return CH_BACKSLASH;
    return 8'($urandom_range(255));
  endfunction

  // random strings of 1 to 10 bytes, with a stretch of no gaps in the middle
  task automatic test_random_strings();
    int target;
    int len;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      steady = (items_sent > target - 70) && (items_sent < target - 35);
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        send_byte(random_text_byte(), i == len - 1);
      end
    end
    steady = 1'b0;
  endtask

  // result side: random stalls, none during the steady stretch
  always @(negedge clk) begin
    result_if.ready <= steady || ($urandom_range(99) >= STALL_PERCENT);
  end

  // compare every result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      got.out_char   = result_if.out_char;
      got.char_valid = result_if.char_valid;
      got.token_done = result_if.token_done;
      got.input_done = result_if.input_done;
      got.run_last   = result_if.run_last;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result char=%h cv=%b td=%b id=%b last=%b",
                               got.out_char, got.char_valid, got.token_done,
                               got.input_done, got.run_last));
      end else begin
        want = expected_results.pop_front();
        if (got.out_char !== want.out_char || got.char_valid !== want.char_valid ||
            got.token_done !== want.token_done || got.input_done !== want.input_done ||
            got.run_last !== want.run_last) begin
          note_failure($sformatf({"result mismatch: expected char=%h cv=%b td=%b id=%b",
                                  " last=%b, got char=%h cv=%b td=%b id=%b last=%b"},
                                 want.out_char, want.char_valid, want.token_done,
                                 want.input_done, want.run_last, got.out_char,
                                 got.char_valid, got.token_done, got.input_done,
                                 got.run_last));
        end
      end
    end
  end

  // ends the run when neither side has a transfer for too long
  always @(posedge clk) begin
    if ((byte_in_if.valid && byte_in_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst                 = 1'b1;
    byte_in_if.valid    = 1'b0;
    byte_in_if.in_char  = CH_NUL;
    byte_in_if.is_final = 1'b0;
    result_if.ready     = 1'b0;
    quote_state         = QM_NONE;
    token_active        = 1'b0;
    escape_pending      = 1'b0;
    fail_count          = 0;
    items_sent          = 0;
    quiet_cycles        = 0;
    steady              = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_plain_words();
    test_double_quotes();
    test_single_quotes();
    test_string_ends();
    test_random_strings();

    byte_in_if.valid <= 1'b0;
    // let every owed result come out, then watch for strays
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
